>>> rtl/fpcr_pkg.sv
package fpcr_pkg;

  // default fraction bits of the row coefficients
  localparam int COEF_FRAC_BITS_DEF = 12;

  // field widths
  localparam int N_W    = 16;
  localparam int CFG_W  = 16;
  localparam int COEF_W = 18;
  localparam int OFF_W  = 17;
  localparam int ROW_W  = 3;
  localparam int MAG_W  = 32;   // magnitude of squares and cross products
  localparam int MT_W   = 32;   // mu / sqrt(2), 30 fraction bits
  localparam int ACC_W  = 40;   // working width of row terms

  // words buffered between the front and the back
  localparam int QUEUE_DEPTH = 8;

  // round(2^16 / sqrt 2)
  localparam logic [CFG_W-1:0] INV_SQRT2_Q16 = 16'd46341;

  // register reset values
  localparam logic [CFG_W-1:0] MU_RESET      = 16'd8192;
  localparam logic [CFG_W-1:0] MIN_F_RESET   = 16'd0;
  localparam logic [CFG_W-1:0] MAX_F_RESET   = 16'hFFFF;

  // register indexes
  typedef enum logic [1:0] {
    CFG_MU    = 2'd0,
    CFG_MIN_F = 2'd1,
    CFG_MAX_F = 2'd2
  } cfg_idx_e;

  // row codes, in emission order
  localparam logic [ROW_W-1:0] ROW_T_POS = 3'd0;
  localparam logic [ROW_W-1:0] ROW_T_NEG = 3'd1;
  localparam logic [ROW_W-1:0] ROW_B_POS = 3'd2;
  localparam logic [ROW_W-1:0] ROW_B_NEG = 3'd3;
  localparam logic [ROW_W-1:0] ROW_N_POS = 3'd4;
  localparam logic [ROW_W-1:0] ROW_N_NEG = 3'd5;

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t COEF_MAX = 40'sd131071;
  localparam acc_t COEF_MIN = -40'sd131072;

  // side data that travels beside the dividers
  typedef struct packed {
    acc_t term_x;
    acc_t term_y;
    acc_t term_z;
    acc_t nf_x;
    acc_t nf_y;
    acc_t nf_z;
    logic neg_t1;
    logic neg_t2;
    logic neg_b2;
    logic nn_zero;
    logic s_zero;
  } meta_t;

  // one queued normal, ready for row generation
  typedef struct packed {
    acc_t t_x;
    acc_t t_y;
    acc_t t_z;
    acc_t b_y;
    acc_t b_z;
    acc_t term_x;
    acc_t term_y;
    acc_t term_z;
    acc_t nf_x;
    acc_t nf_y;
    acc_t nf_z;
    logic degen;
  } rowsrc_t;

  // saturate a row term to the coefficient range
  function automatic logic signed [COEF_W-1:0] sat_coef(acc_t v);
    logic signed [COEF_W-1:0] r;
    if (v > COEF_MAX) begin
      r = COEF_MAX[COEF_W-1:0];
    end else if (v < COEF_MIN) begin
      r = COEF_MIN[COEF_W-1:0];
    end else begin
      r = v[COEF_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/fpcr_if.sv
interface fpcr_in_if import fpcr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [N_W-1:0] normal_x;
  logic signed [N_W-1:0] normal_y;
  logic signed [N_W-1:0] normal_z;

  modport source (output valid, normal_x, normal_y, normal_z, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, output ready);
endinterface

interface fpcr_out_if import fpcr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ROW_W-1:0]         row_index;
  logic signed [COEF_W-1:0] coef_x;
  logic signed [COEF_W-1:0] coef_y;
  logic signed [COEF_W-1:0] coef_z;
  logic signed [OFF_W-1:0]  row_offset;
  logic                     degenerate;
  logic                     last_row;

  modport source (output valid, row_index, coef_x, coef_y, coef_z, row_offset, degenerate,
                  last_row, input ready);
  modport sink   (input valid, row_index, coef_x, coef_y, coef_z, row_offset, degenerate,
                  last_row, output ready);
endinterface

>>> rtl/fpcr_div_lane.sv
// Pipelined restoring divider, one quotient bit per stage.
// Gives floor((2*num*2^(QB-2) + den) / (2*den)), i.e. num/den rounded
// to QB-2 fraction bits, half away from zero.
module fpcr_div_lane import fpcr_pkg::*; #(
  parameter int QB = COEF_FRAC_BITS_DEF + 2
) (
  input  logic             clk_i,
  input  logic [MAG_W-1:0] num_i,
  input  logic [MAG_W-1:0] den_i,
  output logic [QB-1:0]    quo_o
);

  localparam int NW = MAG_W + QB;
  localparam int RW = MAG_W + 2;
  localparam int DW = MAG_W + 1;

  logic [NW-1:0] num_ext;
  logic [RW-1:0] rem_in [QB];
  logic [QB-1:0] low_in [QB];
  logic [DW-1:0] dsr_in [QB];
  logic [RW-1:0] rem_q  [QB];
  logic [QB-1:0] low_q  [QB];
  logic [DW-1:0] dsr_q  [QB];

  // dividend with the rounding half added
  assign num_ext = ({num_i, {QB{1'b0}}} >> 1) + NW'(den_i);

  genvar g;
  for (g = 0; g < QB; g++) begin : g_stage
    logic [RW:0] trial;
    logic [RW:0] diff;
    logic        ge;

    if (g == 0) begin : g_first
      assign rem_in[g] = RW'(num_ext[NW-1:QB]);
      assign low_in[g] = num_ext[QB-1:0];
      assign dsr_in[g] = {den_i, 1'b0};
    end else begin : g_next
      assign rem_in[g] = rem_q[g-1];
      assign low_in[g] = low_q[g-1];
      assign dsr_in[g] = dsr_q[g-1];
    end

    assign trial = {rem_in[g], low_in[g][QB-1]};
    assign ge    = trial >= (RW+1)'(dsr_in[g]);
    assign diff  = trial - (RW+1)'(dsr_in[g]);

    always_ff @(posedge clk_i) begin
      rem_q[g] <= ge ? diff[RW-1:0] : trial[RW-1:0];
      low_q[g] <= {low_in[g][QB-2:0], ge};
      dsr_q[g] <= dsr_in[g];
    end
  end

  assign quo_o = low_q[QB-1];

endmodule

>>> rtl/fpcr_front.sv
// Front end: takes normals, forms products, runs the five divisions and
// pushes finished frame terms into the queue. Credits keep the pipe from
// ever overrunning the queue.
module fpcr_front import fpcr_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  fpcr_in_if.sink          in_i,
  input  logic [CFG_W-1:0] mu_i,
  input  logic             pop_i,
  output logic             push_o,
  output rowsrc_t          push_data_o
);

  localparam int   QB     = COEF_FRAC_BITS + 2;
  localparam int   K_TERM = 42 - COEF_FRAC_BITS;
  localparam int   SH_UP  = (COEF_FRAC_BITS >= 12) ? COEF_FRAC_BITS - 12 : 0;
  localparam int   SH_DN  = (COEF_FRAC_BITS < 12) ? 12 - COEF_FRAC_BITS : 1;
  localparam int   CW     = $clog2(QUEUE_DEPTH + 1);
  localparam acc_t ONE    = acc_t'(1) <<< COEF_FRAC_BITS;

  // n * mu~ (42 fraction bits) rounded to the coefficient format
  function automatic acc_t round_term(logic signed [48:0] v);
    logic [47:0] mag;
    logic [48:0] sum;
    logic [48:0] rd;
    mag = v[48] ? 48'(-v) : v[47:0];
    sum = {1'b0, mag} + (49'(1) << (K_TERM - 1));
    rd  = sum >> K_TERM;
    return v[48] ? -acc_t'(rd) : acc_t'(rd);
  endfunction

  // Q4.12 normal rescaled to the coefficient format
  function automatic acc_t rescale_n(logic signed [N_W-1:0] v);
    logic [N_W:0] mag;
    logic [N_W:0] rd;
    acc_t         r;
    mag = v[N_W-1] ? (N_W+1)'(-v) : (N_W+1)'(v);
    rd  = (mag + ((N_W+1)'(1) << (SH_DN - 1))) >> SH_DN;
    if (COEF_FRAC_BITS >= 12) begin
      r = acc_t'(v) <<< SH_UP;
    end else begin
      r = v[N_W-1] ? -acc_t'(rd) : acc_t'(rd);
    end
    return r;
  endfunction

  logic [CW-1:0] cnt_q, cnt_d;
  logic          acc;
  logic [MT_W-1:0] mt_q;

  // stage 1: captured normal
  logic v1_q;
  logic signed [N_W-1:0] nx1_q, ny1_q, nz1_q;

  // stage 2: products
  logic v2_q;
  logic signed [MAG_W-1:0] sqx_q, sqy_q, sqz_q, pxy_q, pxz_q, pyz_q;
  logic signed [48:0]      trx_q, try_q, trz_q;
  logic signed [N_W-1:0]   nx2_q, ny2_q, nz2_q;
  logic signed [MAG_W-1:0] sqx_d, sqy_d, sqz_d, pxy_d, pxz_d, pyz_d;
  logic signed [48:0]      trx_d, try_d, trz_d;

  // stage 3: divider operands and side data
  logic v3_q;
  logic [MAG_W-1:0] nn_d, s_d;
  logic [MAG_W-1:0] nn3_q, s3_q;
  logic [MAG_W-1:0] num3_q [5];
  meta_t meta_d, meta3_q;

  // divider side pipe
  logic  vpipe_q [QB];
  meta_t mpipe_q [QB];
  logic [QB-1:0] quo [5];
  meta_t m;

  // credit count: items in flight plus queued
  assign in_i.ready = cnt_q < CW'(QUEUE_DEPTH);
  assign acc        = in_i.valid & in_i.ready;
  assign cnt_d      = cnt_q + CW'(acc) - CW'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      v1_q  <= acc;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
    end
  end

  // products
  assign sqx_d = nx1_q * nx1_q;
  assign sqy_d = ny1_q * ny1_q;
  assign sqz_d = nz1_q * nz1_q;
  assign pxy_d = nx1_q * ny1_q;
  assign pxz_d = nx1_q * nz1_q;
  assign pyz_d = ny1_q * nz1_q;
  assign trx_d = nx1_q * $signed({1'b0, mt_q});
  assign try_d = ny1_q * $signed({1'b0, mt_q});
  assign trz_d = nz1_q * $signed({1'b0, mt_q});

  // squared norms, signs and side terms
  assign nn_d = MAG_W'(sqx_q) + MAG_W'(sqy_q) + MAG_W'(sqz_q);
  assign s_d  = MAG_W'(sqy_q) + MAG_W'(sqz_q);

  always_comb begin
    meta_d.term_x  = round_term(trx_q);
    meta_d.term_y  = round_term(try_q);
    meta_d.term_z  = round_term(trz_q);
    meta_d.nf_x    = rescale_n(nx2_q);
    meta_d.nf_y    = rescale_n(ny2_q);
    meta_d.nf_z    = rescale_n(nz2_q);
    meta_d.neg_t1  = pxy_q > 0;
    meta_d.neg_t2  = pxz_q > 0;
    meta_d.neg_b2  = pyz_q > 0;
    meta_d.nn_zero = nn_d == '0;
    meta_d.s_zero  = s_d == '0;
  end

  always_ff @(posedge clk_i) begin
    mt_q  <= MT_W'(mu_i) * MT_W'(INV_SQRT2_Q16);
    nx1_q <= in_i.normal_x;
    ny1_q <= in_i.normal_y;
    nz1_q <= in_i.normal_z;
    sqx_q <= sqx_d;
    sqy_q <= sqy_d;
    sqz_q <= sqz_d;
    pxy_q <= pxy_d;
    pxz_q <= pxz_d;
    pyz_q <= pyz_d;
    trx_q <= trx_d;
    try_q <= try_d;
    trz_q <= trz_d;
    nx2_q <= nx1_q;
    ny2_q <= ny1_q;
    nz2_q <= nz1_q;
    nn3_q <= nn_d;
    s3_q  <= s_d;
    num3_q[0] <= s_d;
    num3_q[1] <= pxy_q[MAG_W-1] ? MAG_W'(-pxy_q) : MAG_W'(pxy_q);
    num3_q[2] <= pxz_q[MAG_W-1] ? MAG_W'(-pxz_q) : MAG_W'(pxz_q);
    num3_q[3] <= MAG_W'(sqz_q);
    num3_q[4] <= pyz_q[MAG_W-1] ? MAG_W'(-pyz_q) : MAG_W'(pyz_q);
    meta3_q <= meta_d;
  end

  // dividers: three over nn for the tangent, two over s for the binormal
  genvar l;
  for (l = 0; l < 5; l++) begin : g_lane
    fpcr_div_lane #(.QB(QB)) u_div (
      .clk_i (clk_i),
      .num_i (num3_q[l]),
      .den_i ((l < 3) ? nn3_q : s3_q),
      .quo_o (quo[l])
    );
  end

  // side data delayed to match the dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QB; i++) vpipe_q[i] <= 1'b0;
    end else begin
      vpipe_q[0] <= v3_q;
      for (int i = 1; i < QB; i++) vpipe_q[i] <= vpipe_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    mpipe_q[0] <= meta3_q;
    for (int i = 1; i < QB; i++) mpipe_q[i] <= mpipe_q[i-1];
  end

  // apply signs and the degenerate frames
  assign m      = mpipe_q[QB-1];
  assign push_o = vpipe_q[QB-1];

  always_comb begin
    push_data_o.t_x    = m.nn_zero ? ONE : acc_t'(quo[0]);
    push_data_o.t_y    = m.nn_zero ? '0 :
                         (m.neg_t1 ? -acc_t'(quo[1]) : acc_t'(quo[1]));
    push_data_o.t_z    = m.nn_zero ? '0 :
                         (m.neg_t2 ? -acc_t'(quo[2]) : acc_t'(quo[2]));
    push_data_o.b_y    = m.s_zero ? ONE : acc_t'(quo[3]);
    push_data_o.b_z    = m.s_zero ? '0 :
                         (m.neg_b2 ? -acc_t'(quo[4]) : acc_t'(quo[4]));
    push_data_o.term_x = m.term_x;
    push_data_o.term_y = m.term_y;
    push_data_o.term_z = m.term_z;
    push_data_o.nf_x   = m.nf_x;
    push_data_o.nf_y   = m.nf_y;
    push_data_o.nf_z   = m.nf_z;
    push_data_o.degen  = m.nn_zero | m.s_zero;
  end

endmodule

>>> rtl/fpcr_queue.sv
// Small FIFO of prepared normals between front and back.
module fpcr_queue import fpcr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  rowsrc_t push_data_i,
  input  logic    pop_i,
  output rowsrc_t head_o,
  output logic    nempty_o,
  output logic    full_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rowsrc_t       mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PW'(1);
      if (pop_i)  rd_q <= rd_q + PW'(1);
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  assign head_o   = mem_q[rd_q];
  assign nempty_o = cnt_q != '0;
  assign full_o   = cnt_q == CW'(DEPTH);

endmodule

>>> rtl/fpcr_back.sv
// Back end: walks the six rows of the queue head into the output register.
module fpcr_back import fpcr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rowsrc_t          head_i,
  input  logic             nempty_i,
  input  logic [CFG_W-1:0] min_f_i,
  input  logic [CFG_W-1:0] max_f_i,
  output logic             pop_o,
  fpcr_out_if.source       out_o
);

  logic [ROW_W-1:0] row_q;
  logic             valid_q;
  logic             load;
  acc_t             cx, cy, cz;
  logic signed [OFF_W-1:0] off;

  assign load  = nempty_i & (~valid_q | out_o.ready);
  assign pop_o = load & (row_q == ROW_N_NEG);

  // row terms before saturation
  always_comb begin
    cx  = '0;
    cy  = '0;
    cz  = '0;
    off = '0;
    case (row_q)
      ROW_T_POS: begin
        cx = head_i.t_x - head_i.term_x;
        cy = head_i.t_y - head_i.term_y;
        cz = head_i.t_z - head_i.term_z;
      end
      ROW_T_NEG: begin
        cx = -head_i.t_x - head_i.term_x;
        cy = -head_i.t_y - head_i.term_y;
        cz = -head_i.t_z - head_i.term_z;
      end
      ROW_B_POS: begin
        cx = -head_i.term_x;
        cy = head_i.b_y - head_i.term_y;
        cz = head_i.b_z - head_i.term_z;
      end
      ROW_B_NEG: begin
        cx = -head_i.term_x;
        cy = -head_i.b_y - head_i.term_y;
        cz = -head_i.b_z - head_i.term_z;
      end
      ROW_N_POS: begin
        cx  = head_i.nf_x;
        cy  = head_i.nf_y;
        cz  = head_i.nf_z;
        off = -$signed({1'b0, max_f_i});
      end
      ROW_N_NEG: begin
        cx  = -head_i.nf_x;
        cy  = -head_i.nf_y;
        cz  = -head_i.nf_z;
        off = $signed({1'b0, min_f_i});
      end
      default: begin
        cx = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= ROW_T_POS;
      valid_q <= 1'b0;
    end else begin
      valid_q <= load | (valid_q & ~out_o.ready);
      if (load) row_q <= (row_q == ROW_N_NEG) ? ROW_T_POS : row_q + ROW_W'(1);
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_o.row_index  <= row_q;
      out_o.coef_x     <= sat_coef(cx);
      out_o.coef_y     <= sat_coef(cy);
      out_o.coef_z     <= sat_coef(cz);
      out_o.row_offset <= off;
      out_o.degenerate <= head_i.degen;
      out_o.last_row   <= row_q == ROW_N_NEG;
    end
  end

  assign out_o.valid = valid_q;

endmodule

>>> rtl/friction_pyramid_constraint_rows.sv
// Each normal gives six row words, back to back while the receiver is ready; the
// single row-per-cycle output register, held while the receiver stalls, sets the rate,
// and the divider pipe takes a normal each cycle while credits remain.
// Up to 8 normals are held in flight between the front pipe and the row queue.
// Reset (async, active low) empties the pipe and queue and loads mu = 0.5,
// min force 0 and max force 65535.
module friction_pyramid_constraint_rows import fpcr_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  fpcr_in_if.sink          in_i,
  fpcr_out_if.source       out_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  logic [CFG_W-1:0] mu_q, min_f_q, max_f_q;
  logic    q_push, q_pop, q_nempty, q_full;
  rowsrc_t q_wdata, q_head;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q    <= MU_RESET;
      min_f_q <= MIN_F_RESET;
      max_f_q <= MAX_F_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MU)    mu_q    <= cfg_data_i;
      if (cfg_idx_i == CFG_MIN_F) min_f_q <= cfg_data_i;
      if (cfg_idx_i == CFG_MAX_F) max_f_q <= cfg_data_i;
    end
  end

  fpcr_front #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .mu_i        (mu_q),
    .pop_i       (q_pop),
    .push_o      (q_push),
    .push_data_o (q_wdata)
  );

  fpcr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .nempty_o    (q_nempty),
    .full_o      (q_full)
  );

  fpcr_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (q_head),
    .nempty_i (q_nempty),
    .min_f_i  (min_f_q),
    .max_f_i  (max_f_q),
    .pop_o    (q_pop),
    .out_o    (out_o)
  );

  // credits must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (!q_full || q_pop))
    else $error("row queue overflow");

  // a pop only retires a queued word
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_nempty)
    else $error("pop from empty row queue");

  // the last-row flag marks the minus-normal row
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last_row) |-> (out_o.row_index == ROW_N_NEG))
    else $error("last_row on wrong row");

endmodule

>>> dv/friction_pyramid_constraint_rows_tb.sv
`timescale 1ns / 100ps

module friction_pyramid_constraint_rows_tb;
  import fpcr_pkg::*;

  localparam int F = COEF_FRAC_BITS_DEF;
  localparam logic [1:0] CFG_UNUSED = 2'd3;   // no register behind this index
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;           // beyond the front pipe latency

  typedef struct {
    logic [ROW_W-1:0]         row;
    logic signed [COEF_W-1:0] cx;
    logic signed [COEF_W-1:0] cy;
    logic signed [COEF_W-1:0] cz;
    logic signed [OFF_W-1:0]  off;
    logic                     degen;
    logic                     last;
  } row_word_t;

  // Pyramid row predictor and in-order checker
  class pyramid_rows_sb;
    row_word_t  pending_rows[$];
    logic [15:0] mu, min_f, max_f;
    int errors, normals, rows, degen_normals;

    function new();
      mu = MU_RESET; min_f = MIN_F_RESET; max_f = MAX_F_RESET;
      errors = 0; normals = 0; rows = 0; degen_normals = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      if (idx == CFG_MU) mu = val;
      else if (idx == CFG_MIN_F) min_f = val;
      else if (idx == CFG_MAX_F) max_f = val;
    endfunction

    // round to nearest, ties away from zero; den > 0
    function longint div_round(longint num, longint den);
      longint mag, q;
      mag = num < 0 ? -num : num;
      q = (2 * mag + den) / (2 * den);
      return num < 0 ? -q : q;
    endfunction

    function longint to_coef(longint v, int frac);
      if (F >= frac) return v * (longint'(1) << (F - frac));
      return div_round(v, longint'(1) << (frac - F));
    endfunction

    function logic signed [COEF_W-1:0] clip(longint v);
      if (v > 131071) return 18'sd131071;
      if (v < -131072) return -18'sd131072;
      return v[COEF_W-1:0];
    endfunction

    function void note_normal(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
      longint n[3], t[3], b[3], term[3], nf[3], c[3];
      longint one, nn, s, mt;
      logic degen;
      row_word_t w;
      one = longint'(1) << F;
      n[0] = x; n[1] = y; n[2] = z;
      nn = n[0]*n[0] + n[1]*n[1] + n[2]*n[2];
      s = n[1]*n[1] + n[2]*n[2];
      degen = 1'b0;
      // tangent: unit X projected off n
      if (nn == 0) begin
        degen = 1'b1;
        t[0] = one; t[1] = 0; t[2] = 0;
      end else begin
        t[0] = div_round(s * one, nn);
        t[1] = div_round(-n[0] * n[1] * one, nn);
        t[2] = div_round(-n[0] * n[2] * one, nn);
      end
      // binormal: unit Y projected off n and t
      if (s == 0) begin
        degen = 1'b1;
        b[0] = 0; b[1] = one; b[2] = 0;
      end else begin
        b[0] = 0;
        b[1] = div_round(n[2] * n[2] * one, s);
        b[2] = div_round(-n[1] * n[2] * one, s);
      end
      mt = longint'(mu) * longint'(INV_SQRT2_Q16);
      for (int i = 0; i < 3; i++) begin
        term[i] = to_coef(n[i] * mt, 42);
        nf[i] = to_coef(n[i], 12);
      end
      normals++;
      if (degen) degen_normals++;
      for (int r = 0; r < 6; r++) begin
        w.row = r[ROW_W-1:0];
        w.off = '0;
        for (int i = 0; i < 3; i++) begin
          case (w.row)
            ROW_T_POS: c[i] = t[i] - term[i];
            ROW_T_NEG: c[i] = -t[i] - term[i];
            ROW_B_POS: c[i] = b[i] - term[i];
            ROW_B_NEG: c[i] = -b[i] - term[i];
            ROW_N_POS: c[i] = nf[i];
            default:   c[i] = -nf[i];
          endcase
        end
        if (w.row == ROW_N_POS) w.off = OFF_W'(-longint'(max_f));
        if (w.row == ROW_N_NEG) w.off = OFF_W'(longint'(min_f));
        w.cx = clip(c[0]); w.cy = clip(c[1]); w.cz = clip(c[2]);
        w.degen = degen;
        w.last = (w.row == ROW_N_NEG);
        pending_rows.push_back(w);
      end
    endfunction

    function void check_row(row_word_t got);
      row_word_t e;
      rows++;
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected row word, row %0d", $time, got.row);
        errors++;
        return;
      end
      e = pending_rows.pop_front();
      if (got.row !== e.row) begin
        $display("%0t: row_index exp %0d got %0d", $time, e.row, got.row); errors++;
      end
      if (got.cx !== e.cx) begin
        $display("%0t: coef_x row %0d exp %0d got %0d", $time, e.row, e.cx, got.cx); errors++;
      end
      if (got.cy !== e.cy) begin
        $display("%0t: coef_y row %0d exp %0d got %0d", $time, e.row, e.cy, got.cy); errors++;
      end
      if (got.cz !== e.cz) begin
        $display("%0t: coef_z row %0d exp %0d got %0d", $time, e.row, e.cz, got.cz); errors++;
      end
      if (got.off !== e.off) begin
        $display("%0t: row_offset row %0d exp %0d got %0d", $time, e.row, e.off, got.off);
        errors++;
      end
      if (got.degen !== e.degen) begin
        $display("%0t: degenerate row %0d exp %b got %b", $time, e.row, e.degen, got.degen);
        errors++;
      end
      if (got.last !== e.last) begin
        $display("%0t: last_row row %0d exp %b got %b", $time, e.row, e.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  bit no_gaps;
  int idle_cycles;
  pyramid_rows_sb sb;

  fpcr_in_if  in_if ();
  fpcr_out_if out_if ();

  friction_pyramid_constraint_rows DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if.sink),
    .out_o      (out_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  initial begin
    sb = new();
    in_if.valid = 1'b0;
    in_if.normal_x = '0; in_if.normal_y = '0; in_if.normal_z = '0;
    out_if.ready = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = CFG_MU; cfg_data_i = '0;
    no_gaps = 1'b0;
    rst_ni = 1'b0;
  end

  // row word checker and stall watchdog
  always @(posedge clk_i) begin
    row_word_t w;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        w.row = out_if.row_index; w.cx = out_if.coef_x; w.cy = out_if.coef_y;
        w.cz = out_if.coef_z; w.off = out_if.row_offset;
        w.degen = out_if.degenerate; w.last = out_if.last_row;
        sb.check_row(w);
      end
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no word moved for %0d cycles", $time, idle_cycles);
        $display("friction_pyramid_constraint_rows regression: fail");
        $finish;
      end
    end
  end

  // receiver: random stall before each row word
  initial begin
    int w;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      w = no_gaps ? 0 : $urandom_range(0, 4);
      if (w > 0) begin
        out_if.ready <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      @(negedge clk_i);
    end
  end

  // entered and left at a falling edge
  task automatic send_normal(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.normal_x <= x; in_if.normal_y <= y; in_if.normal_z <= z;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_normal(x, y, z);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.pending_rows.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_comp(int kind);
    case (kind)
      0: return 16'($urandom());
      1: return 16'($signed($urandom_range(0, 8192)) - 4096);   // near unit
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  task automatic random_normals(int count);
    int kind;
    logic [15:0] x, y, z;
    for (int k = 0; k < count; k++) begin
      kind = $urandom_range(0, 9);
      x = rand_comp(kind < 4 ? 0 : kind < 7 ? 1 : kind < 9 ? 2 : 3);
      y = rand_comp(kind < 4 ? 0 : kind < 7 ? 1 : kind < 9 ? 2 : 3);
      z = rand_comp(kind < 4 ? 0 : kind < 7 ? 1 : kind < 9 ? 2 : 3);
      // occasional zero or X-parallel normal
      if ($urandom_range(0, 19) == 0) begin
        y = '0; z = '0;
        if ($urandom_range(0, 1) == 0) x = '0;
      end
      send_normal(x, y, z);
      if (k == count / 2 && $urandom_range(0, 1) == 0) no_gaps = ~no_gaps;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset settings, extremes and degenerate normals
    send_normal(16'sd0, 16'sd0, 16'sd0);
    send_normal(16'sd4096, 16'sd0, 16'sd0);
    send_normal(-16'sd32768, 16'sd0, 16'sd0);
    send_normal(16'sd0, 16'sd4096, 16'sd0);
    send_normal(16'sd0, 16'sd0, 16'sd4096);
    send_normal(16'sd0, 16'sd0, -16'sd4096);
    send_normal(16'sd32767, 16'sd32767, 16'sd32767);
    send_normal(-16'sd32768, -16'sd32768, -16'sd32768);
    send_normal(16'sd32767, -16'sd32768, 16'sd1);
    send_normal(16'sd1, 16'sd1, -16'sd1);
    send_normal(16'sd2365, 16'sd2365, 16'sd2365);
    send_normal(-16'sd1, 16'sd0, 16'sd0);
    send_normal(16'sd0, -16'sd32768, 16'sd0);
    // hold off until the pipe is empty once
    wait_drained();

    // extreme register values
    write_reg(CFG_MU, 16'hFFFF);
    write_reg(CFG_MIN_F, 16'hFFFF);
    write_reg(CFG_MAX_F, 16'h0000);
    write_reg(CFG_UNUSED, 16'h1234);
    send_normal(16'sd32767, 16'sd32767, 16'sd32767);
    send_normal(-16'sd32768, 16'sd100, -16'sd32768);
    send_normal(16'sd0, 16'sd0, 16'sd0);
    send_normal(16'sd0, 16'sd0, 16'sd4096);
    random_normals(80);
    wait_drained();

    write_reg(CFG_MU, 16'h0000);
    write_reg(CFG_MIN_F, 16'h0000);
    write_reg(CFG_MAX_F, 16'hFFFF);
    no_gaps = 1'b1;
    random_normals(80);
    wait_drained();

    for (int p = 0; p < 3; p++) begin
      write_reg(CFG_MU, 16'($urandom()));
      write_reg(CFG_MIN_F, 16'($urandom()));
      write_reg(CFG_MAX_F, 16'($urandom()));
      no_gaps = (p == 1);
      random_normals(85);
      wait_drained();
    end

    $display("Checked %0d normals (%0d degenerate), %0d row words, over six register settings.",
             sb.normals, sb.degen_normals, sb.rows);
    if (sb.errors == 0 && sb.pending_rows.size() == 0) begin
      $display("friction_pyramid_constraint_rows regression: pass");
    end else begin
      $display("%0d mismatches, %0d row words never seen", sb.errors, sb.pending_rows.size());
      $display("friction_pyramid_constraint_rows regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/fpcr_pkg.sv
rtl/fpcr_if.sv
rtl/fpcr_div_lane.sv
rtl/fpcr_front.sv
rtl/fpcr_queue.sv
rtl/fpcr_back.sv
rtl/friction_pyramid_constraint_rows.sv
dv/friction_pyramid_constraint_rows_tb.sv
